### rtl/core/mss_pkg.sv
// Package: shared types and constants of the MLP smootherstep scorer.
`default_nettype none
package mss_pkg;

  localparam int INPUT_COUNT_DEF  = 8;
  localparam int HIDDEN_COUNT_DEF = 8;
  localparam int ADDR_W  = 7;
  localparam int VALUE_W = 32;
  localparam int SCORE_W = 32;
  localparam int ACT_W   = 17;

  // One unit of 1.0 in Q16.16 / Q1.16
  localparam int ONE_Q16   = 65536;
  localparam int SCORE_CAP = 65470;

  // Work item handed from the front to the back
  typedef struct packed {
    logic                 wr_w;  // write a parameter word
    logic                 wr_f;  // write a feature
    logic                 run;   // score the vector
    logic [ADDR_W-1:0]    addr;
    logic [VALUE_W-1:0]   value;
  } cmd_t;

endpackage
`default_nettype wire

### rtl/core/mss_req_if.sv
// Interface: request channel (parameter writes and features).
`default_nettype none
interface mss_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [mss_pkg::ADDR_W-1:0]        address;
  logic signed [mss_pkg::VALUE_W-1:0] value;
  logic                              last_feature;

  modport source (output valid, req_type, address, value, last_feature, input ready);
  modport sink   (input valid, req_type, address, value, last_feature, output ready);
endinterface
`default_nettype wire

### rtl/core/mss_score_if.sv
// Interface: score result channel.
`default_nettype none
interface mss_score_if;
  logic                        valid;
  logic                        ready;
  logic [mss_pkg::SCORE_W-1:0] score;

  modport source (output valid, score, input ready);
  modport sink   (input valid, score, output ready);
endinterface
`default_nettype wire

### rtl/core/mss_front.sv
// Front: accepts request items, classifies them and pushes work into the queue.
`default_nettype none
module mss_front #(
  parameter int INPUT_COUNT  = mss_pkg::INPUT_COUNT_DEF,
  parameter int HIDDEN_COUNT = mss_pkg::HIDDEN_COUNT_DEF
) (
  mss_req_if.sink         in_i,
  input  wire logic       full_i,
  output mss_pkg::cmd_t   cmd_o,
  output logic            push_o
);
  localparam int STORE_WORDS = 2*INPUT_COUNT + 2*HIDDEN_COUNT + HIDDEN_COUNT*INPUT_COUNT + 1;

  logic wr_w, wr_f, run;

  always_comb begin
    wr_w = !in_i.req_type && (32'(in_i.address) < 32'(STORE_WORDS));
    wr_f = in_i.req_type && (32'(in_i.address) < 32'(INPUT_COUNT));
    run  = in_i.req_type && in_i.last_feature;
    cmd_o.wr_w  = wr_w;
    cmd_o.wr_f  = wr_f;
    cmd_o.run   = run;
    cmd_o.addr  = in_i.address;
    cmd_o.value = in_i.value;
  end

  assign in_i.ready = !full_i;
  // items that touch nothing are dropped here
  assign push_o = in_i.valid && !full_i && (wr_w || wr_f || run);

endmodule
`default_nettype wire

### rtl/core/mss_queue.sv
// Queue: two-entry FIFO of work items between front and back.
`default_nettype none
module mss_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  mss_pkg::cmd_t       cmd_i,
  output logic                full_o,
  output logic                valid_o,
  output mss_pkg::cmd_t       head_o,
  input  wire logic           pop_i
);
  mss_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= cmd_i;
  end

endmodule
`default_nettype wire

### rtl/core/mss_back.sv
// Back: parameter and feature stores, shared MAC and smootherstep sequencer.
`default_nettype none
module mss_back #(
  parameter int INPUT_COUNT  = mss_pkg::INPUT_COUNT_DEF,
  parameter int HIDDEN_COUNT = mss_pkg::HIDDEN_COUNT_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  mss_pkg::cmd_t   head_i,
  output logic            pop_o,
  output logic            busy_o,
  mss_score_if.source     out_o
);
  localparam int OFS_IN_W    = 0;
  localparam int OFS_IN_B    = OFS_IN_W + INPUT_COUNT;
  localparam int OFS_HID_B   = OFS_IN_B + INPUT_COUNT;
  localparam int OFS_HID_W   = OFS_HID_B + HIDDEN_COUNT;
  localparam int OFS_OUT_W   = OFS_HID_W + HIDDEN_COUNT*INPUT_COUNT;
  localparam int OFS_OUT_B   = OFS_OUT_W + HIDDEN_COUNT;
  localparam int STORE_WORDS = OFS_OUT_B + 1;
  localparam int WAW  = $clog2(STORE_WORDS);
  localparam int FAW  = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int AAW  = $clog2(INPUT_COUNT + HIDDEN_COUNT);
  localparam int MAXC = (INPUT_COUNT > HIDDEN_COUNT) ? INPUT_COUNT : HIDDEN_COUNT;
  localparam int CW   = $clog2(MAXC + 1);
  localparam int AW   = mss_pkg::ACT_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_BIAS_RD  = 4'd1;
  localparam logic [3:0] S_BIAS_ACC = 4'd2;
  localparam logic [3:0] S_TERM_RD  = 4'd3;
  localparam logic [3:0] S_TERM_MUL = 4'd4;
  localparam logic [3:0] S_TERM_ACC = 4'd5;
  localparam logic [3:0] S_SM_X     = 4'd6;
  localparam logic [3:0] S_SM_P1    = 4'd7;
  localparam logic [3:0] S_SM_P2    = 4'd8;
  localparam logic [3:0] S_SM_P3    = 4'd9;
  localparam logic [3:0] S_SM_P4    = 4'd10;
  localparam logic [3:0] S_SM_W     = 4'd11;

  localparam logic [1:0] L_IN  = 2'd0;
  localparam logic [1:0] L_HID = 2'd1;
  localparam logic [1:0] L_OUT = 2'd2;

  logic [3:0]    state_q, state_d;
  logic [1:0]    layer_q, layer_d;
  logic [CW-1:0] n_q, n_d, t_q, t_d;
  logic [WAW-1:0] hptr_q, hptr_d;

  // stores
  logic [31:0]    wmem [STORE_WORDS];
  logic [31:0]    fmem [INPUT_COUNT];
  logic [AW-1:0]  amem [INPUT_COUNT + HIDDEN_COUNT];
  logic [31:0]    wd_q, fd_q;
  logic [AW-1:0]  ad_q;
  logic [WAW-1:0] w_raddr;
  logic [FAW-1:0] f_raddr;
  logic [AAW-1:0] a_raddr, a_waddr;
  logic           a_we;

  // datapath
  logic signed [63:0] acc_q, prod_q;
  logic [AW-1:0]      x_q;
  logic [20:0]        a_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [21:0] inner;
  logic signed [63:0] y, a_sum, s_sh;
  logic [AW-1:0]      x_cl, s_cl;
  logic [15:0]        cap;
  logic               out_valid_q;
  logic [31:0]        score_q;

  logic [CW-1:0] n_cnt, t_cnt;
  logic          do_pop, last_n, last_t, out_free;

  always_comb begin
    case (layer_q)
      L_IN:    begin n_cnt = CW'(INPUT_COUNT);  t_cnt = CW'(1); end
      L_HID:   begin n_cnt = CW'(HIDDEN_COUNT); t_cnt = CW'(INPUT_COUNT); end
      default: begin n_cnt = CW'(1);            t_cnt = CW'(HIDDEN_COUNT); end
    endcase
  end
  assign last_n   = n_q == n_cnt - CW'(1);
  assign last_t   = t_q == t_cnt - CW'(1);
  assign out_free = !out_valid_q || out_o.ready;

  // read addresses
  always_comb begin
    if (state_q == S_BIAS_RD) begin
      case (layer_q)
        L_IN:    w_raddr = WAW'(OFS_IN_B) + WAW'(n_q);
        L_HID:   w_raddr = WAW'(OFS_HID_B) + WAW'(n_q);
        default: w_raddr = WAW'(OFS_OUT_B);
      endcase
    end else begin
      case (layer_q)
        L_IN:    w_raddr = WAW'(OFS_IN_W) + WAW'(n_q);
        L_HID:   w_raddr = hptr_q;
        default: w_raddr = WAW'(OFS_OUT_W) + WAW'(t_q);
      endcase
    end
    f_raddr = FAW'(n_q);
    if (layer_q == L_HID) a_raddr = AAW'(t_q);
    else                  a_raddr = AAW'(INPUT_COUNT) + AAW'(t_q);
    if (layer_q == L_IN)  a_waddr = AAW'(n_q);
    else                  a_waddr = AAW'(INPUT_COUNT) + AAW'(n_q);
  end

  assign do_pop = (state_q == S_IDLE) && valid_i;
  assign pop_o  = do_pop;
  assign busy_o = state_q != S_IDLE;
  assign a_we   = (state_q == S_SM_W) && (layer_q != L_OUT);

  always_ff @(posedge clk_i) begin
    if (do_pop && head_i.wr_w) wmem[WAW'(head_i.addr)] <= head_i.value;
    wd_q <= wmem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (do_pop && head_i.wr_f) fmem[FAW'(head_i.addr)] <= head_i.value;
    fd_q <= fmem[f_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (a_we) amem[a_waddr] <= s_cl;
    ad_q <= amem[a_raddr];
  end

  // shared multiplier operands
  always_comb begin
    inner = $signed({5'b0, x_q}) * 22'sd6 - 22'sd983040;
    case (state_q)
      S_TERM_MUL: begin
        mul_a = {wd_q[31], wd_q};
        if (layer_q == L_IN) mul_b = {fd_q[31], fd_q};
        else                 mul_b = {16'b0, ad_q};
      end
      S_SM_P1: begin mul_a = {16'b0, x_q}; mul_b = {{11{inner[21]}}, inner}; end
      S_SM_P2: begin mul_a = {16'b0, x_q}; mul_b = {16'b0, x_q}; end
      S_SM_P3: begin mul_a = {16'b0, prod_q[32:16]}; mul_b = {16'b0, x_q}; end
      S_SM_P4: begin mul_a = {16'b0, prod_q[32:16]}; mul_b = {12'b0, a_q}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = mul_a * mul_b;
  end

  // clamps
  always_comb begin
    y = acc_q >>> 16;
    if (y < 0)                      x_cl = '0;
    else if (y > 64'(mss_pkg::ONE_Q16)) x_cl = AW'(mss_pkg::ONE_Q16);
    else                            x_cl = y[AW-1:0];
    a_sum = (prod_q >>> 16) + 64'sd655360;
    s_sh  = prod_q >>> 16;
    if (s_sh < 0)                        s_cl = '0;
    else if (s_sh > 64'(mss_pkg::ONE_Q16)) s_cl = AW'(mss_pkg::ONE_Q16);
    else                                 s_cl = s_sh[AW-1:0];
    cap = (s_cl > AW'(mss_pkg::SCORE_CAP)) ? 16'(mss_pkg::SCORE_CAP) : s_cl[15:0];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_BIAS_ACC: acc_q <= {{16{wd_q[31]}}, wd_q, 16'b0};
      S_TERM_ACC: acc_q <= acc_q + prod_q;
      default:    acc_q <= acc_q;
    endcase
    if (state_q == S_SM_X) x_q <= x_cl;
    if (state_q == S_SM_P2) a_q <= a_sum[20:0];
    if (state_q == S_TERM_MUL || state_q == S_SM_P1 || state_q == S_SM_P2 ||
        state_q == S_SM_P3 || state_q == S_SM_P4) prod_q <= mul_p[63:0];
    if (state_q == S_SM_W && layer_q == L_OUT && out_free) score_q <= {cap, cap};
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    layer_d = layer_q;
    n_d     = n_q;
    t_d     = t_q;
    hptr_d  = hptr_q;
    case (state_q)
      S_IDLE: begin
        if (do_pop && head_i.run) begin
          state_d = S_BIAS_RD;
          layer_d = L_IN;
          n_d     = '0;
          t_d     = '0;
          hptr_d  = WAW'(OFS_HID_W);
        end
      end
      S_BIAS_RD:  state_d = S_BIAS_ACC;
      S_BIAS_ACC: state_d = S_TERM_RD;
      S_TERM_RD:  state_d = S_TERM_MUL;
      S_TERM_MUL: state_d = S_TERM_ACC;
      S_TERM_ACC: begin
        if (layer_q == L_HID) hptr_d = hptr_q + WAW'(1);
        if (last_t) begin
          t_d     = '0;
          state_d = S_SM_X;
        end else begin
          t_d     = t_q + CW'(1);
          state_d = S_TERM_RD;
        end
      end
      S_SM_X:  state_d = S_SM_P1;
      S_SM_P1: state_d = S_SM_P2;
      S_SM_P2: state_d = S_SM_P3;
      S_SM_P3: state_d = S_SM_P4;
      S_SM_P4: state_d = S_SM_W;
      S_SM_W: begin
        if (layer_q == L_OUT) begin
          if (out_free) state_d = S_IDLE;
        end else if (last_n) begin
          n_d     = '0;
          layer_d = (layer_q == L_IN) ? L_HID : L_OUT;
          state_d = S_BIAS_RD;
        end else begin
          n_d     = n_q + CW'(1);
          state_d = S_BIAS_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      layer_q     <= L_IN;
      n_q         <= '0;
      t_q         <= '0;
      hptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      layer_q <= layer_d;
      n_q     <= n_d;
      t_q     <= t_d;
      hptr_q  <= hptr_d;
      if (state_q == S_SM_W && layer_q == L_OUT && out_free) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.score = score_q;

endmodule
`default_nettype wire

### rtl/core/mlp_smootherstep_scorer.sv
// Top level: MLP smootherstep scorer (front, work queue, compute back end).
`default_nettype none
// Scores a feature vector with a one-hidden-layer perceptron. Parameter-write
// items (req_type 0) fill the weight store; feature items (req_type 1) fill the
// feature store, and the one flagged last_feature starts scoring and yields one
// score item. The back end takes writes and features only while it is idle;
// a two-entry queue holds up to two items while a score is computed.
// Scoring runs on a single shared 33x33 multiplier with registered store
// reads. The score waits in an output register; a new vector can be
// accepted meanwhile.
module mlp_smootherstep_scorer #(
  parameter int INPUT_COUNT  = mss_pkg::INPUT_COUNT_DEF,
  parameter int HIDDEN_COUNT = mss_pkg::HIDDEN_COUNT_DEF
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  mss_req_if.sink      in_i,
  mss_score_if.source  out_o
);
  mss_pkg::cmd_t push_cmd, head_cmd;
  logic          push, full, head_valid, pop, busy;

  mss_front #(
    .INPUT_COUNT (INPUT_COUNT),
    .HIDDEN_COUNT(HIDDEN_COUNT)
  ) u_front (
    .in_i  (in_i),
    .full_i(full),
    .cmd_o (push_cmd),
    .push_o(push)
  );

  mss_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .valid_o(head_valid),
    .head_o (head_cmd),
    .pop_i  (pop)
  );

  mss_back #(
    .INPUT_COUNT (INPUT_COUNT),
    .HIDDEN_COUNT(HIDDEN_COUNT)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(head_valid),
    .head_i (head_cmd),
    .pop_o  (pop),
    .busy_o (busy),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full)) else $error("push into full queue");
  a_pop_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid) else $error("pop from empty queue");
  a_score_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(busy)) else $error("score without a run");
  a_busy_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !pop) else $error("queue popped while scoring");
`endif

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Testbench: MLP smootherstep scorer, directed table plus random vectors, predictor-checked.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NIN   = mss_pkg::INPUT_COUNT_DEF;
  localparam int NHID  = mss_pkg::HIDDEN_COUNT_DEF;
  localparam int OFS_IN_B  = NIN;
  localparam int OFS_HID_B = 2 * NIN;
  localparam int OFS_HID_W = 2 * NIN + NHID;
  localparam int OFS_OUT_W = OFS_HID_W + NHID * NIN;
  localparam int OFS_OUT_B = OFS_OUT_W + NHID;
  localparam int WORDS     = OFS_OUT_B + 1;
  localparam logic REQ_PARAM   = 1'b0;
  localparam logic REQ_FEATURE = 1'b1;
  localparam logic [31:0] SCORE_TOP = 32'd4290707390;
  localparam int RANDOM_ITEMS = 2000;

  typedef struct packed {
    logic        req;
    logic [6:0]  addr;
    logic [31:0] value;
    logic        last;
    logic        has_score;
    logic [31:0] score;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  mss_req_if   req_if();
  mss_score_if score_if();

  mlp_smootherstep_scorer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (score_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [31:0] weight_mem [WORDS];
  logic [31:0] feature_mem [NIN];
  logic [31:0] score_q [$];
  int          fails = 0;
  bit          quiet_in = 1'b0;
  bit          quiet_out = 1'b0;
  dir_row_t    dir_rows [18];

  function automatic longint floor_q16(longint v);
    return v >>> 16;
  endfunction

  function automatic longint smootherstep_q16(longint xin);
    longint x, inner, a, c, s;
    x = xin;
    if (x < 0) x = 0;
    if (x > mss_pkg::ONE_Q16) x = mss_pkg::ONE_Q16;
    inner = 6 * x - 15 * longint'(mss_pkg::ONE_Q16);
    a = floor_q16(x * inner) + 10 * longint'(mss_pkg::ONE_Q16);
    c = ((x * x) >>> 16) * x >>> 16;
    s = floor_q16(c * a);
    if (s < 0) s = 0;
    if (s > mss_pkg::ONE_Q16) s = mss_pkg::ONE_Q16;
    return s;
  endfunction

  function automatic longint wq(int idx);
    return longint'($signed(weight_mem[idx]));
  endfunction

  function automatic logic [31:0] score_vector();
    longint acc, act;
    longint in_act [NIN];
    longint hid_act [NHID];
    logic [31:0] prod;
    for (int i = 0; i < NIN; i++) begin
      acc = wq(i) * longint'($signed(feature_mem[i])) + wq(OFS_IN_B + i) * 65536;
      in_act[i] = smootherstep_q16(floor_q16(acc));
    end
    for (int h = 0; h < NHID; h++) begin
      acc = wq(OFS_HID_B + h) * 65536;
      for (int j = 0; j < NIN; j++)
        acc += wq(OFS_HID_W + h * NIN + j) * in_act[j];
      hid_act[h] = smootherstep_q16(floor_q16(acc));
    end
    acc = wq(OFS_OUT_B) * 65536;
    for (int h = 0; h < NHID; h++) acc += wq(OFS_OUT_W + h) * hid_act[h];
    act = smootherstep_q16(floor_q16(acc));
    if (act > mss_pkg::SCORE_CAP) act = mss_pkg::SCORE_CAP;
    prod = 32'(act * 65537);
    return prod;
  endfunction

  // Updates the stores; returns 1 and the score when the item starts a run.
  function automatic bit apply_item(logic req, logic [6:0] addr, logic [31:0] value,
                                    logic last, output logic [31:0] score);
    score = '0;
    if (req == REQ_PARAM) begin
      if (addr < WORDS) weight_mem[addr] = value;
      return 1'b0;
    end
    if (addr < NIN) feature_mem[addr] = value;
    if (!last) return 1'b0;
    score = score_vector();
    return 1'b1;
  endfunction

  task automatic send_item(logic req, logic [6:0] addr, logic [31:0] value, logic last,
                           bit typed = 1'b0, logic [31:0] typed_score = '0);
    int gap;
    logic [31:0] sc;
    gap = quiet_in ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid        = 1'b1;
    req_if.req_type     = req;
    req_if.address      = addr;
    req_if.value        = value;
    req_if.last_feature = last;
    // ready only moves after a rising edge, so its value here holds at the next one
    while (!req_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    if (apply_item(req, addr, value, last, sc)) score_q.push_back(typed ? typed_score : sc);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 262144)) - 131072);
      2: return 32'($signed($urandom_range(0, 65536)) - 32768);
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 1048576)) - 524288);
    endcase
  endfunction

  // Score receiver with random back-pressure
  initial begin
    int stall;
    logic [31:0] got;
    score_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = quiet_out ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        score_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      score_if.ready = 1'b1;
      while (!score_if.valid) @(negedge clk_i);
      got = score_if.score;
      @(posedge clk_i);
      if (score_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected score: expected none, actual %0d", $time, got);
      end else begin
        logic [31:0] want;
        want = score_q.pop_front();
        if (got !== want) begin
          fails++;
          $display("%0t: score mismatch: expected %0d, actual %0d", $time, want, got);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int sent, waited, k;
    logic [6:0] a;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_PARAM;
    req_if.address = '0;
    req_if.value = '0;
    req_if.last_feature = 1'b0;

    //             req          addr           value         last has score
    dir_rows[0]  = '{REQ_FEATURE, 7'd127,        32'h0,        1'b1, 1'b1, 32'd0};
    dir_rows[1]  = '{REQ_PARAM,   7'(OFS_OUT_B), 32'h00010000, 1'b1, 1'b0, 32'd0};
    dir_rows[2]  = '{REQ_FEATURE, 7'd0,          32'h7fffffff, 1'b1, 1'b1, SCORE_TOP};
    dir_rows[3]  = '{REQ_PARAM,   7'(OFS_OUT_B), 32'h7fffffff, 1'b0, 1'b0, 32'd0};
    dir_rows[4]  = '{REQ_FEATURE, 7'd7,          32'h80000000, 1'b1, 1'b1, SCORE_TOP};
    dir_rows[5]  = '{REQ_PARAM,   7'(OFS_OUT_B), 32'h80000000, 1'b0, 1'b0, 32'd0};
    dir_rows[6]  = '{REQ_FEATURE, 7'd3,          32'hffffffff, 1'b1, 1'b1, 32'd0};
    dir_rows[7]  = '{REQ_PARAM,   7'd97,         32'h12345678, 1'b0, 1'b0, 32'd0};
    dir_rows[8]  = '{REQ_PARAM,   7'd127,        32'hffffffff, 1'b1, 1'b0, 32'd0};
    dir_rows[9]  = '{REQ_FEATURE, 7'd0,          32'h00000001, 1'b1, 1'b1, 32'd0};
    dir_rows[10] = '{REQ_PARAM,   7'(OFS_OUT_B), 32'h00008000, 1'b0, 1'b0, 32'd0};
    dir_rows[11] = '{REQ_FEATURE, 7'd8,          32'h5a5a5a5a, 1'b1, 1'b1, 32'd2147516416};
    dir_rows[12] = '{REQ_PARAM,   7'd0,          32'h00010000, 1'b0, 1'b0, 32'd0};
    dir_rows[13] = '{REQ_PARAM,   7'(OFS_IN_B),  32'hffff8000, 1'b0, 1'b0, 32'd0};
    dir_rows[14] = '{REQ_PARAM,   7'(OFS_HID_W), 32'h00020000, 1'b0, 1'b0, 32'd0};
    dir_rows[15] = '{REQ_PARAM,   7'(OFS_OUT_W), 32'hfffe0000, 1'b0, 1'b0, 32'd0};
    dir_rows[16] = '{REQ_FEATURE, 7'd0,          32'h00018000, 1'b0, 1'b0, 32'd0};
    dir_rows[17] = '{REQ_FEATURE, 7'd1,          32'h80000000, 1'b1, 1'b0, 32'd0};

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // every store entry written before any run reads it
    for (int i = 0; i < WORDS; i++) send_item(REQ_PARAM, 7'(i), 32'h0, 1'b0);
    for (int i = 0; i < NIN; i++) send_item(REQ_FEATURE, 7'(i), 32'h0, 1'b0);

    foreach (dir_rows[r])
      send_item(dir_rows[r].req, dir_rows[r].addr, dir_rows[r].value, dir_rows[r].last,
                dir_rows[r].has_score, dir_rows[r].score);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) quiet_in = ~quiet_in;
      if ($urandom_range(0, 9) == 0) quiet_out = ~quiet_out;
      if ($urandom_range(0, 99) < 85) begin
        // parameter tweaks, then a full feature vector
        k = $urandom_range(0, 8);
        for (int i = 0; i < k; i++) begin
          send_item(REQ_PARAM, 7'($urandom_range(0, WORDS - 1)), rand_value(),
                    1'($urandom_range(0, 1)));
          sent++;
        end
        for (int i = 0; i < NIN; i++) begin
          a = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(NIN, 127)) : 7'(i);
          send_item(REQ_FEATURE, a, rand_value(), 1'(i == NIN - 1));
          sent++;
        end
      end else begin
        send_item(1'($urandom_range(0, 1)), 7'($urandom), $urandom,
                  1'($urandom_range(0, 3) == 0));
        sent++;
      end
    end
    req_if.valid = 1'b0;

    waited = 0;
    while (score_q.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (1000) @(posedge clk_i);
    if (fails == 0 && score_q.size() == 0) begin
      $display("tb: success");
    end else begin
      if (score_q.size() != 0)
        $display("%0t: missing scores: expected %0d more, actual 0", $time, score_q.size());
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
